// File: hdl/lpp_pkg.sv
// Shared types and constants for the LL(1) predictive parser.
package lpp_pkg;
  localparam int NUM_TERMINALS    = 64;
  localparam int NUM_NONTERMINALS = 64;
  localparam int NUM_RULES        = 128;
  localparam int MAX_RHS          = 8;
  localparam int STACK_DEPTH      = 256;
  localparam int EXPANSION_LIMIT  = 4096;

  localparam int TOK_W  = 6;
  localparam int NT_W   = 6;
  localparam int RULE_W = 7;
  localparam int SYM_W  = 7;
  localparam int SLOT_W = 3;
  localparam int LEN_W  = 4;
  localparam int SP_W   = 9;
  localparam int SA_W   = 8;
  localparam int TBL_W  = NT_W + TOK_W;
  localparam int PRD_W  = RULE_W + SLOT_W;
  localparam int CNT_W  = 13;

  localparam logic [TOK_W-1:0] END_MARKER = '0;
  localparam logic [LEN_W-1:0] MAX_LEN    = LEN_W'(MAX_RHS);
  localparam logic [SP_W:0]    SP_LIMIT   = (SP_W+1)'(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_TOKEN = 2'd1,
    ACT_TABLE = 2'd2,
    ACT_PROD  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CONSUMED = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_NOENTRY  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_IDLE     = 3'd5,
    ST_WRITTEN  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BEGIN2, S_CHECK, S_TBL, S_LEN,
    S_PRD, S_PWR, S_FETCH, S_FETCHW, S_DONE
  } state_t;

  typedef struct packed {
    action_t            act;
    logic [TOK_W-1:0]   token;
    logic [NT_W-1:0]    nonterminal;
    logic [RULE_W-1:0]  rule;
    logic               entry_valid;
    logic [SLOT_W-1:0]  rhs_slot;
    logic [SYM_W-1:0]   rhs_symbol;
    logic [LEN_W-1:0]   rhs_length;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [SYM_W-1:0]   top_symbol;
    logic [7:0]         expansions;
    logic [RULE_W-1:0]  last_rule;
  } result_t;
endpackage

// File: hdl/lpp_front.sv
// Input side: two-entry item queue with action decode.
module lpp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              clearing,
  input  logic [1:0]        action,
  input  logic [5:0]        token,
  input  logic [5:0]        nonterminal,
  input  logic [6:0]        rule,
  input  logic              entry_valid,
  input  logic [2:0]        rhs_slot,
  input  logic [6:0]        rhs_symbol,
  input  logic [3:0]        rhs_length,
  output lpp_pkg::item_t    item,
  output logic              item_valid,
  input  logic              item_pop
);
  import lpp_pkg::*;

  item_t       q [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        do_push, do_pop;
  item_t       incoming;

  always_comb begin
    incoming.act         = action_t'(action);
    incoming.token       = token;
    incoming.nonterminal = nonterminal;
    incoming.rule        = rule;
    incoming.entry_valid = entry_valid;
    incoming.rhs_slot    = rhs_slot;
    incoming.rhs_symbol  = rhs_symbol;
    // length above the right-hand side capacity saturates
    incoming.rhs_length  = (rhs_length > MAX_LEN) ? MAX_LEN : rhs_length;
  end

  assign full       = (count == 2'd2) || clearing;
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// File: hdl/lpp_resq.sv
// Output side: two-entry result queue.
module lpp_resq (
  input  logic              clk,
  input  logic              rst,
  input  lpp_pkg::result_t  res_in,
  input  logic              res_push,
  output logic              res_full,
  output lpp_pkg::result_t  res_out,
  output logic              empty,
  input  logic              pop
);
  import lpp_pkg::*;

  result_t     q [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        do_push, do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = q[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= res_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

// File: hdl/lpp_back.sv
// Parse engine: stack, parse table and production memories with the step sequencer.
module lpp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [5:0]        start_symbol,
  input  lpp_pkg::item_t    item,
  input  logic              item_valid,
  output logic              item_pop,
  output logic              clearing,
  output lpp_pkg::result_t  res,
  output logic              res_push,
  input  logic              res_full
);
  import lpp_pkg::*;

  logic [SYM_W-1:0]   stack_mem [STACK_DEPTH];
  logic [RULE_W:0]    tbl_mem   [NUM_NONTERMINALS*NUM_TERMINALS];
  logic [SYM_W-1:0]   prd_mem   [NUM_RULES*MAX_RHS];
  logic [LEN_W-1:0]   len_mem   [NUM_RULES];

  state_t             state, state_next;
  logic [SP_W-1:0]    sp, sp_next;
  logic [SYM_W-1:0]   tos, tos_next;
  logic               active, active_next;
  logic [TOK_W-1:0]   tok, tok_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [RULE_W-1:0]  last, last_next;
  logic [RULE_W-1:0]  cur_rule, cur_rule_next;
  logic [LEN_W-1:0]   left, left_next;
  logic               to_check, to_check_next;
  logic [TBL_W-1:0]   clr, clr_next;
  result_t            rr, rr_next;

  logic               stk_we;
  logic [SA_W-1:0]    stk_wa, stk_ra;
  logic [SYM_W-1:0]   stk_wd, stk_q;
  logic               tbl_we;
  logic [TBL_W-1:0]   tbl_wa, tbl_ra;
  logic [RULE_W:0]    tbl_wd, tbl_q;
  logic               prd_we;
  logic [PRD_W-1:0]   prd_ra;
  logic [SYM_W-1:0]   prd_q;
  logic               len_we;
  logic [RULE_W-1:0]  len_ra;
  logic [LEN_W-1:0]   len_q, len_sat;
  logic [SYM_W-1:0]   top_now;
  logic [7:0]         shown;
  logic [SP_W:0]      fit;
  logic [SP_W-1:0]    sp_dec;

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_q <= stack_mem[stk_ra];
  end
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_q <= tbl_mem[tbl_ra];
  end
  always_ff @(posedge clk) begin
    if (prd_we) prd_mem[{item.rule, item.rhs_slot}] <= item.rhs_symbol;
    prd_q <= prd_mem[prd_ra];
  end
  always_ff @(posedge clk) begin
    if (len_we) len_mem[item.rule] <= item.rhs_length;
    len_q <= len_mem[len_ra];
  end

  assign top_now  = (sp != '0) ? tos : '0;
  assign shown    = (count[CNT_W-1:8] != '0) ? 8'hff : count[7:0];
  assign len_sat  = (len_q > MAX_LEN) ? MAX_LEN : len_q;
  assign fit      = {1'b0, sp} + {{(SP_W+1-LEN_W){1'b0}}, len_sat};
  assign sp_dec   = sp - 1'b1;
  assign clearing = (state == S_CLEAR);
  assign res      = rr;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr == '1) state_next = S_IDLE;
      S_IDLE: begin
        if (item_valid) begin
          case (item.act)
            ACT_BEGIN: state_next = S_BEGIN2;
            ACT_TOKEN: state_next = active ? S_CHECK : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_BEGIN2: state_next = S_DONE;
      S_CHECK: begin
        if (sp == '0) state_next = S_DONE;
        else if (tos < SYM_W'(NUM_TERMINALS)) state_next = (tos == {1'b0, tok}) ?
                                                            S_FETCH : S_DONE;
        else state_next = S_TBL;
      end
      S_TBL:    state_next = tbl_q[RULE_W] ? S_LEN : S_DONE;
      S_LEN: begin
        if (count[CNT_W-1] || fit > SP_LIMIT) state_next = S_DONE;
        else if (len_sat == '0) state_next = S_FETCH;
        else state_next = S_PRD;
      end
      S_PRD:    state_next = S_PWR;
      S_PWR:    state_next = (left == LEN_W'(1)) ? S_CHECK : S_PRD;
      S_FETCH:  state_next = S_FETCHW;
      S_FETCHW: state_next = to_check ? S_CHECK : S_DONE;
      S_DONE:   if (!res_full) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    sp_next       = sp;
    tos_next      = tos;
    active_next   = active;
    tok_next      = tok;
    count_next    = count;
    last_next     = last;
    cur_rule_next = cur_rule;
    left_next     = left;
    to_check_next = to_check;
    clr_next      = clr;
    rr_next       = rr;
    item_pop      = 1'b0;
    res_push      = 1'b0;
    stk_we        = 1'b0;
    stk_wa        = sp[SA_W-1:0];
    stk_wd        = tos;
    stk_ra        = sp_dec[SA_W-1:0];
    tbl_we        = 1'b0;
    tbl_wa        = {item.nonterminal, item.token};
    tbl_wd        = {item.entry_valid, item.entry_valid ? item.rule : RULE_W'(0)};
    tbl_ra        = {tos[NT_W-1:0], tok};
    prd_we        = 1'b0;
    prd_ra        = {cur_rule, SLOT_W'(left - 1'b1)};
    len_we        = 1'b0;
    len_ra        = tbl_q[RULE_W-1:0];
    case (state)
      S_CLEAR: begin
        tbl_we   = 1'b1;
        tbl_wa   = clr;
        tbl_wd   = '0;
        clr_next = clr + 1'b1;
      end
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          rr_next  = '{ST_WRITTEN, top_now, 8'd0, RULE_W'(0)};
          case (item.act)
            ACT_BEGIN: begin
              stk_we      = 1'b1;
              stk_wa      = '0;
              stk_wd      = {1'b0, END_MARKER};
              active_next = 1'b1;
            end
            ACT_TOKEN: begin
              rr_next.status = ST_IDLE;
              tok_next       = item.token;
              count_next     = '0;
              last_next      = '0;
            end
            ACT_TABLE: tbl_we = 1'b1;
            ACT_PROD: begin
              prd_we = 1'b1;
              len_we = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_BEGIN2: begin
        stk_we   = 1'b1;
        stk_wa   = SA_W'(1);
        stk_wd   = {1'b1, start_symbol};
        tos_next = {1'b1, start_symbol};
        sp_next  = SP_W'(2);
        rr_next  = '{ST_WRITTEN, {1'b1, start_symbol}, 8'd0, RULE_W'(0)};
      end
      S_CHECK: begin
        if (sp == '0) begin
          active_next = 1'b0;
          rr_next     = '{ST_MISMATCH, SYM_W'(0), shown, last};
        end else if (tos < SYM_W'(NUM_TERMINALS)) begin
          if (tos != {1'b0, tok}) begin
            active_next = 1'b0;
            rr_next     = '{ST_MISMATCH, tos, shown, last};
          end else begin
            sp_next       = sp_dec;
            to_check_next = 1'b0;
            if (tok == END_MARKER) begin
              active_next = 1'b0;
              rr_next = '{(sp_dec == '0) ? ST_ACCEPTED : ST_MISMATCH, tos, shown, last};
            end else begin
              rr_next = '{ST_CONSUMED, tos, shown, last};
            end
          end
        end
      end
      S_TBL: begin
        cur_rule_next = tbl_q[RULE_W-1:0];
        if (!tbl_q[RULE_W]) begin
          active_next = 1'b0;
          rr_next     = '{ST_NOENTRY, tos, shown, last};
        end
      end
      S_LEN: begin
        if (count[CNT_W-1] || fit > SP_LIMIT) begin
          active_next = 1'b0;
          rr_next     = '{ST_OVERFLOW, tos, shown, last};
        end else begin
          sp_next   = sp_dec;
          left_next = len_sat;
          if (len_sat == '0) begin
            count_next    = count + 1'b1;
            last_next     = cur_rule;
            to_check_next = 1'b1;
          end
        end
      end
      S_PRD: ;
      S_PWR: begin
        // right-hand side goes on in reverse, so the first symbol ends on top
        stk_we    = 1'b1;
        stk_wd    = prd_q;
        tos_next  = prd_q;
        sp_next   = sp + 1'b1;
        left_next = left - 1'b1;
        if (left == LEN_W'(1)) begin
          count_next = count + 1'b1;
          last_next  = cur_rule;
        end
      end
      S_FETCH: ;
      S_FETCHW: begin
        tos_next = stk_q;
        if (!to_check) rr_next.top_symbol = (sp != '0) ? stk_q : '0;
      end
      S_DONE:  res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      sp     <= '0;
      active <= 1'b0;
      clr    <= '0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      active <= active_next;
      clr    <= clr_next;
    end
  end

  always_ff @(posedge clk) begin
    tos      <= tos_next;
    tok      <= tok_next;
    count    <= count_next;
    last     <= last_next;
    cur_rule <= cur_rule_next;
    left     <= left_next;
    to_check <= to_check_next;
    rr       <= rr_next;
  end
endmodule

// File: hdl/ll1_predictive_parser_unit.sv
// Top level of the LL(1) table-driven predictive parser.
//
//  channel   signals                                         handshake
//  input     action token nonterminal rule entry_valid ...   push / full
//  result    status top_symbol expansions last_rule          empty / pop
//  config    start_symbol                                    start_symbol_we
//
// A token steps through the check, table, length and production states, its pace
// set by the registered table, length and production reads.
// After reset the parse table is swept clear with full high.
// Queues of two items on each side let input and result stall independently.
module ll1_predictive_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [5:0]  token,
  input  logic [5:0]  nonterminal,
  input  logic [6:0]  rule,
  input  logic        entry_valid,
  input  logic [2:0]  rhs_slot,
  input  logic [6:0]  rhs_symbol,
  input  logic [3:0]  rhs_length,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [6:0]  top_symbol,
  output logic [7:0]  expansions,
  output logic [6:0]  last_rule,
  input  logic        start_symbol_we,
  input  logic [5:0]  start_symbol
);
  import lpp_pkg::*;

  logic [5:0] start_reg;
  item_t      item;
  logic       item_valid, item_pop, clearing;
  result_t    res, res_out;
  logic       res_push, res_full;

  always_ff @(posedge clk) begin
    if (rst) start_reg <= '0;
    else if (start_symbol_we) start_reg <= start_symbol;
  end

  lpp_front u_front (
    .clk, .rst, .push, .full, .clearing,
    .action, .token, .nonterminal, .rule, .entry_valid,
    .rhs_slot, .rhs_symbol, .rhs_length,
    .item, .item_valid, .item_pop
  );

  lpp_back u_back (
    .clk, .rst, .start_symbol(start_reg),
    .item, .item_valid, .item_pop, .clearing,
    .res, .res_push, .res_full
  );

  lpp_resq u_resq (
    .clk, .rst, .res_in(res), .res_push, .res_full,
    .res_out, .empty, .pop
  );

  assign status     = res_out.status;
  assign top_symbol = res_out.top_symbol;
  assign expansions = res_out.expansions;
  assign last_rule  = res_out.last_rule;
endmodule

// File: verif/ll1_predictive_parser_unit_tb.sv
// Self-checking testbench for the LL(1) predictive parser unit.
module ll1_predictive_parser_unit_tb;
  import lpp_pkg::*;

  // Tracks parser state and holds the results each accepted item should produce.
  class parse_scoreboard;
    bit [5:0]  start_nt;
    bit [6:0]  stk[STACK_DEPTH];
    int        sp;
    bit        tvalid[NUM_NONTERMINALS*NUM_TERMINALS];
    bit [6:0]  trule[NUM_NONTERMINALS*NUM_TERMINALS];
    bit [6:0]  psym[NUM_RULES*MAX_RHS];
    bit [3:0]  plen[NUM_RULES];
    bit        active;
    result_t   pending[$];
    int        errors;

    function bit [6:0] top_sym();
      return sp > 0 ? stk[sp-1] : 7'd0;
    endfunction

    function void note_item(item_t it);
      result_t     res;
      int unsigned cnt, len;
      bit [6:0]    sym, last, r;
      bit [11:0]   tcell;
      bit          done;
      res = '0;
      case (it.act)
        ACT_BEGIN: begin
          stk[0] = 7'd0;
          stk[1] = {1'b1, start_nt};
          sp = 2;
          active = 1;
          res.status = ST_WRITTEN;
          res.top_symbol = top_sym();
        end
        ACT_TOKEN: begin
          if (!active) begin
            res.status = ST_IDLE;
            res.top_symbol = top_sym();
          end else begin
            cnt = 0;
            last = '0;
            done = 0;
            while (!done) begin
              res.expansions = cnt > 255 ? 8'd255 : 8'(cnt);
              res.last_rule = last;
              done = 1;
              if (sp == 0) begin
                active = 0;
                res.status = ST_MISMATCH;
                res.top_symbol = '0;
              end else begin
                sym = stk[sp-1];
                if (sym < 64) begin
                  if (sym[5:0] != it.token) begin
                    active = 0;
                    res.status = ST_MISMATCH;
                    res.top_symbol = sym;
                  end else begin
                    sp--;
                    if (it.token == END_MARKER) begin
                      active = 0;
                      res.status = sp == 0 ? ST_ACCEPTED : ST_MISMATCH;
                    end else
                      res.status = ST_CONSUMED;
                    res.top_symbol = top_sym();
                  end
                end else begin
                  tcell = {sym[5:0], it.token};
                  if (!tvalid[tcell]) begin
                    active = 0;
                    res.status = ST_NOENTRY;
                    res.top_symbol = sym;
                  end else begin
                    r = trule[tcell];
                    len = plen[r] > MAX_RHS ? MAX_RHS : plen[r];
                    if (cnt >= EXPANSION_LIMIT || sp - 1 + len > STACK_DEPTH) begin
                      active = 0;
                      res.status = ST_OVERFLOW;
                      res.top_symbol = sym;
                    end else begin
                      sp--;
                      for (int i = len; i > 0; i--) begin
                        stk[sp] = psym[{r, 3'(i-1)}];
                        sp++;
                      end
                      cnt++;
                      last = r;
                      done = 0;
                    end
                  end
                end
              end
            end
          end
        end
        ACT_TABLE: begin
          tcell = {it.nonterminal, it.token};
          tvalid[tcell] = it.entry_valid;
          trule[tcell] = it.entry_valid ? it.rule : 7'd0;
          res.status = ST_WRITTEN;
          res.top_symbol = top_sym();
        end
        default: begin
          psym[{it.rule, it.rhs_slot}] = it.rhs_symbol;
          plen[it.rule] = it.rhs_length > MAX_LEN ? MAX_LEN : it.rhs_length;
          res.status = ST_WRITTEN;
          res.top_symbol = top_sym();
        end
      endcase
      pending = {pending, res};
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result, status %0d", got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.top_symbol != want.top_symbol) begin
        $error("top_symbol expected %0d actual %0d", want.top_symbol, got.top_symbol);
        errors++;
      end
      if (got.expansions != want.expansions) begin
        $error("expansions expected %0d actual %0d", want.expansions, got.expansions);
        errors++;
      end
      if (got.last_rule != want.last_rule) begin
        $error("last_rule expected %0d actual %0d", want.last_rule, got.last_rule);
        errors++;
      end
    endfunction
  endclass

  // a runaway token runs until the expansion limit stops it
  localparam int CYCLE_LIMIT = 400000000;

  logic       clk = 0;
  logic       rst = 1;
  logic       push = 0;
  logic       full;
  logic [1:0] action = '0;
  logic [5:0] token = '0;
  logic [5:0] nonterminal = '0;
  logic [6:0] rule = '0;
  logic       entry_valid = 0;
  logic [2:0] rhs_slot = '0;
  logic [6:0] rhs_symbol = '0;
  logic [3:0] rhs_length = '0;
  logic       empty;
  logic       pop = 0;
  logic [2:0] status;
  logic [6:0] top_symbol;
  logic [7:0] expansions;
  logic [6:0] last_rule;
  logic       start_symbol_we = 0;
  logic [5:0] start_symbol = '0;

  parse_scoreboard sb = new();
  int send_idle = 7;
  int recv_idle = 49;
  int cycles = 0;

  ll1_predictive_parser_unit u_top (
    .clk, .rst, .push, .full, .action, .token, .nonterminal, .rule, .entry_valid,
    .rhs_slot, .rhs_symbol, .rhs_length, .empty, .pop, .status, .top_symbol,
    .expansions, .last_rule, .start_symbol_we, .start_symbol
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL ll1_predictive_parser_unit");
      $finish;
    end
  end

  always @(negedge clk) pop = $urandom_range(99) >= recv_idle;

  always @(posedge clk)
    if (!rst && pop && !empty)
      sb.check_result('{status_t'(status), top_symbol, expansions, last_rule});

  task automatic send(action_t a, int tok, int nt, int rl, int v, int slot, int sym, int len);
    item_t it;
    it = '{a, 6'(tok), 6'(nt), 7'(rl), 1'(v), 3'(slot), 7'(sym), 4'(len)};
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push = 0;
      @(negedge clk);
    end
    action = it.act;
    token = it.token;
    nonterminal = it.nonterminal;
    rule = it.rule;
    entry_valid = it.entry_valid;
    rhs_slot = it.rhs_slot;
    rhs_symbol = it.rhs_symbol;
    rhs_length = it.rhs_length;
    push = 1;
    do @(posedge clk); while (full);
    sb.note_item(it);
  endtask

  task automatic drain();
    @(negedge clk);
    push = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_start(int v);
    @(negedge clk);
    start_symbol_we = 1;
    start_symbol = 6'(v);
    @(negedge clk);
    start_symbol_we = 0;
    sb.start_nt = 6'(v);
  endtask

  task automatic token_item(int tok);
    send(ACT_TOKEN, tok, $urandom_range(63), $urandom_range(127), $urandom_range(1),
         $urandom_range(7), $urandom_range(127), $urandom_range(15));
  endtask

  task automatic begin_item();
    send(ACT_BEGIN, $urandom_range(63), $urandom_range(63), $urandom_range(127),
         $urandom_range(1), $urandom_range(7), $urandom_range(127), $urandom_range(15));
  endtask

  task automatic table_item(int nt, int tok, int rl, int v);
    send(ACT_TABLE, tok, nt, rl, v, $urandom_range(7), $urandom_range(127),
         $urandom_range(15));
  endtask

  task automatic prod_item(int rl, int slot, int sym, int len);
    send(ACT_PROD, $urandom_range(63), $urandom_range(63), rl, $urandom_range(1),
         slot, sym, len);
  endtask

  // Grammar rules 0..31 own nonterminal r%16; a leading nonterminal is always a
  // higher index, so left recursion only appears through later noise writes.
  task automatic define_rule(int r);
    int len, owner, sym, tok;
    owner = r % 16;
    len = ($urandom_range(9) == 0) ? 8 : $urandom_range(0, 4);
    for (int s = 0; s < MAX_RHS; s++) begin
      if (s == 0 && owner < 15 && $urandom_range(99) < 30)
        sym = 64 + $urandom_range(owner + 1, 15);
      else if (s > 0 && $urandom_range(99) < 40)
        sym = 64 + $urandom_range(0, 15);
      else
        sym = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 63);
      prod_item(r, s, sym, len);
    end
    tok = (len > 0 && sb.psym[{7'(r), 3'd0}] < 64) ? sb.psym[{7'(r), 3'd0}]
                                                    : $urandom_range(1, 63);
    table_item(owner, tok, r, 1);
  endtask

  // Mostly tokens the parser can take next, so parses run deep.
  task automatic random_items(int n);
    int roll, top, cols[$];
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (!sb.active && roll < 85)
        begin_item();
      else if (roll < 80) begin
        top = sb.top_sym();
        if (sb.sp == 0)
          token_item($urandom_range(63));
        else if (top < 64)
          token_item($urandom_range(9) == 0 ? $urandom_range(63) : top);
        else begin
          cols.delete();
          for (int c = 0; c < NUM_TERMINALS; c++)
            if (sb.tvalid[{6'(top - 64), 6'(c)}]) cols = {cols, c};
          token_item(cols.size() == 0 ? $urandom_range(63)
                                      : cols[$urandom_range(cols.size() - 1)]);
        end
      end else if (roll < 88)
        token_item($urandom_range(63));
      else if (roll < 94) begin
        if ($urandom_range(1))
          table_item($urandom_range(63), $urandom_range(63), $urandom_range(0, 31), 1);
        else
          table_item($urandom_range(63), $urandom_range(63), $urandom_range(127), 0);
      end else
        prod_item($urandom_range(1) ? $urandom_range(0, 31) : $urandom_range(32, 122),
                  $urandom_range(7), $urandom_range(127), $urandom_range(15));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 0;
    set_start(63);

    // directed: start nonterminal 63 with one rule per lookahead
    token_item(5);                  // no parse yet
    prod_item(127, 7, 127, 15);     // length saturates
    prod_item(127, 0, 64 + 63, 1);  // 63 -> 63 : runaway
    prod_item(126, 0, 64 + 63, 2);
    prod_item(126, 1, 64 + 63, 2);  // 63 -> 63 63 : stack overflow
    prod_item(125, 0, 7, 1);        // 63 -> 7
    prod_item(124, 0, 0, 1);        // 63 -> $ : end marker with symbols left
    table_item(63, 63, 127, 1);
    table_item(63, 1, 126, 1);
    table_item(63, 7, 125, 1);
    table_item(63, 0, 124, 1);
    begin_item();
    token_item(63);
    begin_item();
    token_item(1);
    begin_item();
    token_item(7);
    token_item(0);                  // accept
    begin_item();
    token_item(7);
    token_item(3);                  // mismatch
    begin_item();
    token_item(0);
    begin_item();
    token_item(5);                  // no entry
    table_item(63, 0, 0, 0);
    drain();

    set_start(0);
    for (int r = 0; r < 32; r++) define_rule(r);
    random_items(450);
    drain();

    send_idle = 49;
    recv_idle = 7;
    set_start($urandom_range(1, 14));
    random_items(450);
    drain();

    send_idle = 0;
    recv_idle = 0;
    set_start(15);
    random_items(450);
    drain();
    repeat (50) @(posedge clk);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS ll1_predictive_parser_unit");
    else
      $display("FAIL ll1_predictive_parser_unit");
    $finish;
  end
endmodule

// File: sim.f
hdl/lpp_pkg.sv
hdl/lpp_front.sv
hdl/lpp_resq.sv
hdl/lpp_back.sv
hdl/ll1_predictive_parser_unit.sv
verif/ll1_predictive_parser_unit_tb.sv
